>>> sv/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, codes and the phone letter maps of the multi-tap entry block.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int MAX_LEN   = 32;
  localparam int LEN_W     = 6;
  localparam int ADDR_W    = 5;
  localparam int NUM_MAPS  = 12;
  localparam int MAP_SLOTS = 9;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PRELOAD = 2'd1,
    CMD_KEY     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_LABEL    = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_SUCCESS  = 2'd2,
    ST_ABORTED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    EDIT_NONE     = 3'd0,
    EDIT_APPENDED = 3'd1,
    EDIT_REPLACED = 3'd2,
    EDIT_REMOVED  = 3'd3,
    EDIT_CLEARED  = 3'd4
  } edit_e;

  typedef enum logic [2:0] {
    REG_MIN_LENGTH  = 3'd0,
    REG_ALLOW_ALPHA = 3'd1,
    REG_ABORT_KEY   = 3'd2,
    REG_CONFIRM_KEY = 3'd3,
    REG_WINDOW      = 3'd4
  } reg_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [7:0]          key_code;
    logic [31:0]         time_ms;
    logic [ADDR_W-1:0]   read_index;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [LEN_W-1:0]    length;
    edit_e               edit_kind;
    logic [7:0]          edit_char;
    logic [7:0]          read_char;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]    min_length;
    logic                allow_alpha;
    logic [7:0]          abort_key;
    logic [7:0]          confirm_key;
    logic [15:0]         cycle_window_ms;
  } cfg_t;

  // One write into the text buffer.
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          data;
  } buf_wr_t;

  // Letter maps: the first character is the key itself; unused slots are zero.
  localparam logic [7:0] MAP_CHAR [NUM_MAPS][MAP_SLOTS] = '{
    '{"1", "-", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"2", "a", "b", "c", "A", "B", "C", 8'h00, 8'h00},
    '{"3", "d", "e", "f", "D", "E", "F", 8'h00, 8'h00},
    '{"4", "g", "h", "i", "G", "H", "I", 8'h00, 8'h00},
    '{"5", "j", "k", "l", "J", "K", "L", 8'h00, 8'h00},
    '{"6", "m", "n", "o", "M", "N", "O", 8'h00, 8'h00},
    '{"7", "p", "q", "r", "s", "P", "Q", "R", "S"},
    '{"8", "t", "u", "v", "T", "U", "V", 8'h00, 8'h00},
    '{"9", "w", "x", "y", "z", "W", "X", "Y", "Z"},
    '{"*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"#", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] MAP_LEN [NUM_MAPS] = '{
    4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd9, 4'd7, 4'd9, 4'd1, 4'd1, 4'd1
  };

  // Next character in the key's letter map. A character not in the map
  // becomes the map's first one; a key with no map leaves it unchanged.
  function automatic logic [7:0] next_in_map(input logic [7:0] key,
                                             input logic [7:0] cur);
    logic [7:0] res;
    logic       hit;
    logic [3:0] pos;
    res = cur;
    for (int m = 0; m < NUM_MAPS; m++) begin
      if (MAP_CHAR[m][0] == key) begin
        hit = 1'b0;
        pos = 4'd0;
        for (int i = 0; i < MAP_SLOTS; i++) begin
          if (!hit && (4'(i) < MAP_LEN[m]) && (MAP_CHAR[m][i] == cur)) begin
            hit = 1'b1;
            pos = (4'(i + 1) == MAP_LEN[m]) ? 4'd0 : 4'(i + 1);
          end
        end
        res = MAP_CHAR[m][pos];
      end
    end
    return res;
  endfunction

endpackage

>>> sv/mte_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_buffer
// Text buffer memory: one write port and two registered read ports, with
// the same-edge write forwarded to both reads.
// ----------------------------------------------------------------------------
module mte_buffer (
  input  wire logic                   clk,
  input  wire mte_pkg::buf_wr_t       wr,
  input  wire logic [mte_pkg::ADDR_W-1:0] last_addr,
  input  wire logic                   idx_en,
  input  wire logic [mte_pkg::ADDR_W-1:0] idx_addr,
  output logic [7:0]                  last_char,
  output logic [7:0]                  idx_char
);
  import mte_pkg::*;

  logic [7:0] mem [MAX_LEN];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Last-character port reads every cycle at the address of the new tail.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == last_addr)) begin
      last_char <= wr.data;
    end else begin
      last_char <= mem[last_addr];
    end
  end

  // Indexed port reads when an item is taken in.
  always_ff @(posedge clk) begin
    if (idx_en) begin
      if (wr.en && (wr.addr == idx_addr)) begin
        idx_char <= wr.data;
      end else begin
        idx_char <= mem[idx_addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mte_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_core
// Session state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module mte_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire mte_pkg::item_t         item,
  input  wire mte_pkg::cfg_t          cfg,
  input  wire logic [7:0]             last_char,
  input  wire logic [7:0]             idx_char,
  output mte_pkg::result_t            res,
  output mte_pkg::buf_wr_t            wr,
  output logic [mte_pkg::ADDR_W-1:0]  last_addr
);
  import mte_pkg::*;

  status_e          status, status_next;
  logic [LEN_W-1:0] len, len_next;
  logic             pending, pending_next;
  logic [7:0]       prev_key, prev_key_next;
  logic [31:0]      prev_time, prev_time_next;

  logic [31:0]      gap;
  logic             repeat_hit;
  logic             can_append;
  logic             min_met;
  logic [7:0]       cycled;
  edit_e            kind;
  logic [7:0]       ech;
  logic [7:0]       rch;

  assign gap        = item.time_ms - prev_time;
  assign repeat_hit = (item.key_code == prev_key) && (gap < {16'd0, cfg.cycle_window_ms});
  assign can_append = len < LEN_W'(MAX_LEN);
  assign min_met    = len >= cfg.min_length;
  assign cycled     = next_in_map(item.key_code, last_char);

  // Next session state and buffer write for the item in the input register.
  always_comb begin
    status_next    = status;
    len_next       = len;
    pending_next   = pending;
    prev_key_next  = prev_key;
    prev_time_next = prev_time;
    kind           = EDIT_NONE;
    ech            = 8'd0;
    rch            = 8'd0;
    wr             = '{en: 1'b0, addr: len[ADDR_W-1:0], data: item.key_code};

    case (item.cmd)
      CMD_START: begin
        status_next    = ST_LABEL;
        len_next       = '0;
        pending_next   = 1'b0;
        prev_key_next  = 8'd0;
        prev_time_next = 32'd0;
        kind           = EDIT_CLEARED;
      end
      CMD_PRELOAD: begin
        if (status == ST_LABEL) begin
          pending_next = 1'b1;
          if (can_append) begin
            wr.en    = 1'b1;
            len_next = len + 1'b1;
            kind     = EDIT_APPENDED;
            ech      = item.key_code;
          end
        end
      end
      CMD_KEY: begin
        if ((item.key_code != 8'd0) && ((status == ST_LABEL) || (status == ST_PROGRESS))) begin
          prev_key_next  = item.key_code;
          prev_time_next = item.time_ms;
          if ((status == ST_LABEL) && (item.key_code == cfg.abort_key)) begin
            status_next = ST_ABORTED;
            len_next    = '0;
            kind        = EDIT_CLEARED;
          end else if ((status == ST_LABEL) && (item.key_code == cfg.confirm_key)) begin
            if (min_met) begin
              status_next = ST_SUCCESS;
            end
          end else begin
            status_next = ST_PROGRESS;
            if ((item.key_code == cfg.abort_key) ||
                ((item.key_code == cfg.confirm_key) && !min_met)) begin
              // Backspace, or abort on an empty buffer.
              if (len != '0) begin
                len_next = len - 1'b1;
                kind     = EDIT_REMOVED;
              end else begin
                status_next = ST_ABORTED;
              end
            end else if (item.key_code == cfg.confirm_key) begin
              status_next = ST_SUCCESS;
            end else if (pending) begin
              // The first ordinary key after preloaded text is swallowed.
              pending_next = 1'b0;
            end else if (cfg.allow_alpha && repeat_hit && (len != '0)) begin
              wr.en   = 1'b1;
              wr.addr = ADDR_W'(len - 1'b1);
              wr.data = cycled;
              kind    = EDIT_REPLACED;
              ech     = cycled;
            end else if (can_append) begin
              wr.en    = 1'b1;
              len_next = len + 1'b1;
              kind     = EDIT_APPENDED;
              ech      = item.key_code;
            end
          end
        end
      end
      CMD_READ: begin
        if ({1'b0, item.read_index} < len) begin
          rch = idx_char;
        end
      end
      default: ;
    endcase
  end

  assign res = '{status: status_next, length: len_next, edit_kind: kind,
                 edit_char: ech, read_char: rch};

  // Tail address for the last-character read port, from the length in force
  // after this edge.
  assign last_addr = ADDR_W'((adv ? len_next : len) - 1'b1);

  // Session state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= ST_LABEL;
      len       <= '0;
      pending   <= 1'b0;
      prev_key  <= 8'd0;
      prev_time <= 32'd0;
    end else if (adv) begin
      status    <= status_next;
      len       <= len_next;
      pending   <= pending_next;
      prev_key  <= prev_key_next;
      prev_time <= prev_time_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/multi_tap_text_entry_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_tap_text_entry_top
// Multi-tap keypad text entry: a bounded text buffer edited by key events.
// ----------------------------------------------------------------------------
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle; the input register and result register
// form a two-stage pipeline that only stalls when the result is not taken.
// Reset (synchronous, rst high) returns configuration to its defaults and
// the session to the label state with an empty buffer; no clearing pass.
module multi_tap_text_entry_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire mte_pkg::item_t    item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output mte_pkg::result_t       result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import mte_pkg::*;

  cfg_t                cfg;
  logic                hold_valid;
  item_t               hold;
  logic                adv;
  logic                accept;
  result_t             res;
  buf_wr_t             wr;
  buf_wr_t             buf_wr;
  logic [ADDR_W-1:0]   last_addr;
  logic [7:0]          last_char;
  logic [7:0]          idx_char;

  // Pipeline control: the held item moves on when the result register frees.
  assign adv        = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && !adv;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // The buffer is only written when the held item actually moves on.
  assign buf_wr.en   = wr.en && adv;
  assign buf_wr.addr = wr.addr;
  assign buf_wr.data = wr.data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{min_length: '0, allow_alpha: 1'b1, abort_key: 8'd42,
               confirm_key: 8'd35, cycle_window_ms: 16'd1000};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_LENGTH:  cfg.min_length      <= cfg_data[LEN_W-1:0];
        REG_ALLOW_ALPHA: cfg.allow_alpha     <= cfg_data[0];
        REG_ABORT_KEY:   cfg.abort_key       <= cfg_data[7:0];
        REG_CONFIRM_KEY: cfg.confirm_key     <= cfg_data[7:0];
        REG_WINDOW:      cfg.cycle_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= accept || (hold_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= adv || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res;
    end
  end

  mte_buffer u_buffer (
    .clk       (clk),
    .wr        (buf_wr),
    .last_addr (last_addr),
    .idx_en    (accept),
    .idx_addr  (item.read_index),
    .last_char (last_char),
    .idx_char  (idx_char)
  );

  mte_core u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .item      (hold),
    .cfg       (cfg),
    .last_char (last_char),
    .idx_char  (idx_char),
    .res       (res),
    .wr        (wr),
    .last_addr (last_addr)
  );

endmodule
`default_nettype wire

>>> sv/mte_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mte_checker
// Port-level checks on the result channel of the text entry block.
// ----------------------------------------------------------------------------
module mte_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             result_valid,
  input  wire logic             result_stall,
  input  wire mte_pkg::result_t result
);
  import mte_pkg::*;

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // The buffer never holds more than its capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.length <= LEN_W'(MAX_LEN)))
    else $error("length beyond capacity");

  // A cleared buffer is reported empty.
  a_cleared_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.edit_kind == EDIT_CLEARED)) |-> (result.length == '0))
    else $error("cleared buffer not empty");

  // A removed character only happens while the session is in progress.
  a_remove_in_progress: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.edit_kind == EDIT_REMOVED)) |->
      (result.status == ST_PROGRESS))
    else $error("character removed outside an active session");

endmodule

bind multi_tap_text_entry_top mte_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire
